/* src/block_pattern_seq_extractor_macros.svh */
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_PATTERN_SEQ_EXTRACTOR_MACROS_SVH
`define BLOCK_PATTERN_SEQ_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BPSE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define BPSE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPSE_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define BPSE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* src/bpse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: package
// Sizes, register indexes and beat types shared by all modules of the block.
// ----------------------------------------------------------------------------
package bpse_pkg;

    // Block geometry and pattern layout.
    localparam int BLOCK_BYTES   = 4 * 1024;
    localparam int PATTERN_BYTES = 16;
    localparam int SEQ_BYTES     = 8;
    localparam int WIN_DEPTH     = PATTERN_BYTES - 1;

    localparam int POS_W    = $clog2(BLOCK_BYTES);
    localparam int CAP_W    = $clog2(SEQ_BYTES + 1);
    localparam int LANE_W   = $clog2(SEQ_BYTES);
    localparam int OFFSET_W = 48;
    localparam int SEQ_W    = 8 * SEQ_BYTES;
    localparam int WORD_W   = 64;

    // Result queue between the scanner and the output stage.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       range_start;
    } in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] block_offset;
        logic [SEQ_W-1:0]    sequence_res;
    } out_t;

    // One finished block: offset relative to the range base offset, and its sequence.
    typedef struct packed {
        logic [OFFSET_W-1:0] rel_offset;
        logic [SEQ_W-1:0]    sequence_val;
    } blk_res_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

/* src/bpse_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: scanner
// Takes one byte per beat, tracks the block position, compares the last
// sixteen bytes with the pattern and captures the eight bytes after the
// first match of each block. Finished blocks with a full capture are pushed
// into the result queue.
// ----------------------------------------------------------------------------
module bpse_front (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  bpse_pkg::in_t                         s_data,
    input  wire  [bpse_pkg::WORD_W-1:0]           pattern_low,
    input  wire  [bpse_pkg::WORD_W-1:0]           pattern_high,
    input  bpse_pkg::fifo_status_t                fifo_status,
    output logic                                  push_valid,
    output bpse_pkg::blk_res_t                    push_data
);
    import bpse_pkg::*;

    localparam logic [POS_W-1:0]    WIN_POS    = POS_W'(WIN_DEPTH);
    localparam logic [POS_W-1:0]    BLOCK_LAST = POS_W'(BLOCK_BYTES - 1);
    localparam logic [CAP_W-1:0]    CAP_FULL   = CAP_W'(SEQ_BYTES);
    localparam logic [OFFSET_W-1:0] BLOCK_STEP = OFFSET_W'(BLOCK_BYTES);

    logic [7:0]          window_reg [WIN_DEPTH];
    logic [POS_W-1:0]    pos_reg;
    logic                matched_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [SEQ_W-1:0]    acc_reg;
    logic [OFFSET_W-1:0] base_reg;

    logic                 accept;
    logic [POS_W-1:0]     pos_eff;
    logic                 matched_eff;
    logic [CAP_W-1:0]     cap_eff;
    logic [OFFSET_W-1:0]  base_eff;
    logic                 matched_next;
    logic [CAP_W-1:0]     cap_next;
    logic [SEQ_W-1:0]     acc_next;
    logic                 hit;
    logic                 block_end;
    logic [8*PATTERN_BYTES-1:0] pattern;

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;
    assign pattern = {pattern_high, pattern_low};

    // A range start drops the partial block and the block count.
    always_comb begin
        pos_eff     = s_data.range_start ? '0 : pos_reg;
        matched_eff = s_data.range_start ? 1'b0 : matched_reg;
        cap_eff     = s_data.range_start ? '0 : cap_reg;
        base_eff    = s_data.range_start ? '0 : base_reg;
    end

    // Sixteen byte compares: window holds pattern bytes 0..14, the new byte is 15.
    always_comb begin
        hit = (s_data.data_byte == pattern[8*WIN_DEPTH +: 8]);
        for (int k = 0; k < WIN_DEPTH; k++) begin
            if (window_reg[k] != pattern[8*k +: 8]) begin
                hit = 1'b0;
            end
        end
    end

    // Match detection and sequence capture for this byte.
    always_comb begin
        matched_next = matched_eff;
        cap_next     = cap_eff;
        acc_next     = acc_reg;
        if (matched_eff) begin
            if (cap_eff < CAP_FULL) begin
                acc_next[8*cap_eff[LANE_W-1:0] +: 8] = s_data.data_byte;
                cap_next = cap_eff + 1'b1;
            end
        end else if (pos_eff >= WIN_POS && hit) begin
            matched_next = 1'b1;
        end
    end

    assign block_end = (pos_eff == BLOCK_LAST);

    // A block that ends with a complete capture yields one result.
    assign push_valid             = accept && block_end && matched_next && (cap_next == CAP_FULL);
    assign push_data.rel_offset   = base_eff;
    assign push_data.sequence_val = acc_next;

    // Block state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            matched_reg <= 1'b0;
            cap_reg     <= '0;
            base_reg    <= '0;
        end else if (accept) begin
            if (block_end) begin
                pos_reg     <= '0;
                matched_reg <= 1'b0;
                cap_reg     <= '0;
                base_reg    <= base_eff + BLOCK_STEP;
            end else begin
                pos_reg     <= pos_eff + 1'b1;
                matched_reg <= matched_next;
                cap_reg     <= cap_next;
                base_reg    <= base_eff;
            end
        end
    end

    // Byte window and capture register; only lanes written in this block are read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[WIN_DEPTH-1] <= s_data.data_byte;
            acc_reg                 <= acc_next;
        end
    end

endmodule

`default_nettype wire

/* src/bpse_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: result queue
// Short queue of finished block results between the scanner and the output
// stage, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module bpse_fifo (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push_valid,
    input  bpse_pkg::blk_res_t     push_data,
    input  wire                    pop,
    output bpse_pkg::blk_res_t     pop_data,
    output bpse_pkg::fifo_status_t status
);
    import bpse_pkg::*;

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    blk_res_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push_valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* src/bpse_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: output stage
// Pops a finished block from the queue, adds the range base offset and holds
// the result beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module bpse_back (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  bpse_pkg::fifo_status_t           fifo_status,
    input  bpse_pkg::blk_res_t               pop_data,
    output logic                             pop,
    input  wire  [bpse_pkg::OFFSET_W-1:0]    base_offset,
    output logic                             m_valid,
    input  wire                              m_ready,
    output bpse_pkg::out_t                   m_data
);
    import bpse_pkg::*;

    logic m_valid_reg;
    out_t m_data_reg;

    assign pop     = !fifo_status.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; the offset sum wraps at 48 bits.
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg.block_offset <= base_offset + pop_data.rel_offset;
            m_data_reg.sequence_res <= pop_data.sequence_val;
        end
    end

endmodule

`default_nettype wire

/* src/block_pattern_seq_extractor.sv */
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte per clock cycle with no gaps of its own while the result
// queue has room: s_ready falls only when both result queue entries still
// hold untaken results. The result of a block is written into the result
// queue at the edge that accepts the block's last byte; the output register
// loads it when it is popped, which waits while the output holds an untaken
// result or older results are queued ahead of it. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: top level
// Scans a byte stream in fixed blocks for a sixteen-byte pattern and reports
// the block offset and the eight-byte little-endian sequence that follows the
// first match of each block whose sequence is complete within the block.
// ----------------------------------------------------------------------------
`include "block_pattern_seq_extractor_macros.svh"

module block_pattern_seq_extractor (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [bpse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [bpse_pkg::WORD_W-1:0]      cfg_data,
    // Byte stream
    input  wire                              s_valid,
    output logic                             s_ready,
    input  bpse_pkg::in_t                    s_data,
    // Results
    output logic                             m_valid,
    input  wire                              m_ready,
    output bpse_pkg::out_t                   m_data
);
    import bpse_pkg::*;

    logic [WORD_W-1:0]   pattern_low_reg;
    logic [WORD_W-1:0]   pattern_high_reg;
    logic [OFFSET_W-1:0] base_offset_reg;

    logic         push_valid;
    blk_res_t     push_data;
    logic         pop;
    blk_res_t     pop_data;
    fifo_status_t fifo_status;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            base_offset_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                CFG_BASE_OFFSET:  base_offset_reg  <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    bpse_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .pattern_low  (pattern_low_reg),
        .pattern_high (pattern_high_reg),
        .fifo_status  (fifo_status),
        .push_valid   (push_valid),
        .push_data    (push_data)
    );

    bpse_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .status     (fifo_status)
    );

    bpse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_status  (fifo_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .base_offset  (base_offset_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // A result is never pushed into a full queue, and a pop always finds one.
    `BPSE_ASSERT_IMPL(a_no_push_when_full, aclk, aresetn, push_valid, !fifo_status.full)
    `BPSE_ASSERT_IMPL(a_no_pop_when_empty, aclk, aresetn, pop, !fifo_status.empty)
    // A pop loads the output register.
    `BPSE_ASSERT_NEXT(a_pop_loads_output, aclk, aresetn, pop, m_valid)

endmodule

`default_nettype wire

/* dv/tb_block_pattern_seq_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pattern sequence extractor: testbench
// Streams whole, late, straddling and broken blocks of bytes into the scanner,
// follows the scan in a scoreboard and checks every reported block offset and
// sequence against it, under changing pattern and offset settings.
// ----------------------------------------------------------------------------
module tb_block_pattern_seq_extractor;
    import bpse_pkg::*;

    localparam int STALL_LIMIT         = 2000;
    localparam int QUIET_CYCLES        = 16;
    localparam int MATCH_ROOM          = PATTERN_BYTES + SEQ_BYTES;
    localparam int RESULTS_PER_SETTING = 6;
    // Index beyond the last register: a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_BASE_OFFSET + 1'b1;

    // Scoreboard: mirrors the scan state and holds the block results still due.
    class seq_match_tracker;
        logic [2*WORD_W-1:0] pattern;
        logic [OFFSET_W-1:0] base_offset;
        logic [7:0]          window [WIN_DEPTH];
        logic [POS_W-1:0]    pos;
        logic [OFFSET_W-1:0] block_count;
        bit                  matched;
        logic [CAP_W-1:0]    captured;
        logic [SEQ_W-1:0]    seq_acc;
        out_t                due_matches [$];
        int                  matches_due_total;
        int                  bad_matches;

        function new();
            pattern = '0;
            base_offset = '0;
            block_count = '0;
            matches_due_total = 0;
            bad_matches = 0;
            clear_block();
        endfunction

        function void clear_block();
            foreach (window[k]) window[k] = 8'h00;
            pos = '0;
            matched = 1'b0;
            captured = '0;
            seq_acc = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                CFG_PATTERN_LOW:  pattern[WORD_W-1:0] = value;
                CFG_PATTERN_HIGH: pattern[2*WORD_W-1:WORD_W] = value;
                CFG_BASE_OFFSET:  base_offset = value[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the scan by one accepted byte beat.
        function void take_byte(in_t beat);
            bit   hit;
            int   k;
            out_t due;
            if (beat.range_start) begin
                block_count = '0;
                clear_block();
            end
            // Capture after the first match, otherwise look for one.
            if (matched) begin
                if (captured < SEQ_BYTES) begin
                    seq_acc[8*captured +: 8] = beat.data_byte;
                    captured++;
                end
            end else if (pos >= WIN_DEPTH) begin
                hit = (beat.data_byte == pattern[8*WIN_DEPTH +: 8]);
                for (k = 0; k < WIN_DEPTH; k++) begin
                    if (window[k] != pattern[8*k +: 8]) hit = 1'b0;
                end
                if (hit) matched = 1'b1;
            end
            for (k = 0; k < WIN_DEPTH - 1; k++) window[k] = window[k+1];
            window[WIN_DEPTH-1] = beat.data_byte;
            // The last byte of a block closes it and may yield its result.
            if (pos == POS_W'(BLOCK_BYTES - 1)) begin
                if (matched && captured == SEQ_BYTES) begin
                    due.block_offset = base_offset + block_count * OFFSET_W'(BLOCK_BYTES);
                    due.sequence_res = seq_acc;
                    due_matches.insert(due_matches.size(), due);
                    matches_due_total++;
                end
                block_count = block_count + 1'b1;
                clear_block();
            end else begin
                pos = pos + 1'b1;
            end
        endfunction

        function void check_match(out_t got);
            out_t want;
            if (due_matches.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual offset %h sequence %h",
                         $time, got.block_offset, got.sequence_res);
                bad_matches++;
            end else begin
                want = due_matches.pop_front();
                if (got.block_offset !== want.block_offset) begin
                    $display("%0t: block_offset mismatch: expected %h, actual %h",
                             $time, want.block_offset, got.block_offset);
                    bad_matches++;
                end
                if (got.sequence_res !== want.sequence_res) begin
                    $display("%0t: sequence_res mismatch: expected %h, actual %h",
                             $time, want.sequence_res, got.sequence_res);
                    bad_matches++;
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;

    seq_match_tracker board = new();

    int src_idle_pct = 35;
    int sink_idle_pct = 64;
    int stall_cycles = 0;

    // Generator view of the stream: current pattern and place in the block.
    logic [2*WORD_W-1:0] cur_pattern = '0;
    int                  stream_pos = 0;
    bit                  open_range = 1'b0;
    bit                  near_miss = 1'b0;

    block_pattern_seq_extractor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    // Result side stalls at random.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Monitor of all three channels, with a watchdog on lack of progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.take_byte(s_data);
            if (m_valid && m_ready) board.check_match(m_data);
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_block_pattern_seq_extractor: FAIL");
                $finish;
            end
        end
    end

    // Offers one byte beat after a random gap and waits for its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        in_t beat;
        beat.data_byte = b;
        beat.range_start = rs;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_byte(b, open_range);
        if (open_range) stream_pos = 0;
        open_range = 1'b0;
        stream_pos = (stream_pos + 1) % BLOCK_BYTES;
    endtask

    task automatic put_pattern();
        for (int k = 0; k < PATTERN_BYTES; k++) put_byte(cur_pattern[8*k +: 8]);
    endtask

    task automatic put_word(input logic [SEQ_W-1:0] value);
        for (int k = 0; k < SEQ_BYTES; k++) put_byte(value[8*k +: 8]);
    endtask

    task automatic put_fill(input logic [7:0] b, input int n);
        for (int i = 0; i < n; i++) put_byte(b);
    endtask

    // Random bytes; in near-miss mode half of them are drawn from the pattern.
    task automatic put_random(input int n);
        int j;
        for (int i = 0; i < n; i++) begin
            if (near_miss && $urandom_range(0, 1)) begin
                j = $urandom_range(0, PATTERN_BYTES - 1);
                put_byte(cur_pattern[8*j +: 8]);
            end else begin
                put_byte(8'($urandom));
            end
        end
    endtask

    function automatic int room_left();
        return open_range ? BLOCK_BYTES : BLOCK_BYTES - stream_pos;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Waits for the results still due to drain, then writes every register.
    task automatic configure(input logic [2*WORD_W-1:0] pat, input logic [WORD_W-1:0] off_word,
                             input bit with_spare);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.due_matches.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        cfg_write(CFG_PATTERN_LOW, pat[WORD_W-1:0]);
        cfg_write(CFG_PATTERN_HIGH, pat[2*WORD_W-1:WORD_W]);
        cfg_write(CFG_BASE_OFFSET, off_word);
        if (with_spare) cfg_write(CFG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        cur_pattern = pat;
    endtask

    // One random scenario, mostly a well-formed block holding the pattern.
    task automatic scan_random_block();
        int r;
        int room;
        int p;
        int k;
        int n;
        near_miss = ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 9) == 0) open_range = 1'b1;
        room = room_left();
        r = $urandom_range(0, 99);
        if (r < 68) begin
            // Full match, or a late one that leaves too few sequence bytes.
            if (room < MATCH_ROOM) begin
                put_random(room);
                room = BLOCK_BYTES;
            end
            if (r < 60) begin
                p = $urandom_range(0, room - MATCH_ROOM);
            end else begin
                p = $urandom_range(room - MATCH_ROOM + 1, room - PATTERN_BYTES);
            end
            put_random(p);
            put_pattern();
            put_random(room - p - PATTERN_BYTES);
        end else if (r < 76) begin
            put_random(room);
        end else if (r < 84) begin
            // Pattern crossing into the next block.
            if (room < PATTERN_BYTES) begin
                put_random(room);
                room = BLOCK_BYTES;
            end
            k = $urandom_range(1, PATTERN_BYTES - 1);
            put_random(room - k);
            put_pattern();
        end else if (r < 92) begin
            // Block cut short by a new range.
            n = $urandom_range(0, room - 1);
            put_random(n);
            if ($urandom_range(0, 1)) put_pattern();
            open_range = 1'b1;
        end else begin
            // Short noise with frequent range starts.
            n = $urandom_range(1, 40);
            for (k = 0; k < n; k++) begin
                open_range = $urandom_range(0, 1);
                put_random(1);
            end
        end
    endtask

    task automatic run_directed();
        // The reset pattern of zeros matches the first sixteen zero bytes,
        // with the stream counted as a range that began at reset.
        put_fill(8'h00, PATTERN_BYTES);
        put_word({$urandom, $urandom});
        put_fill(8'h00, BLOCK_BYTES - MATCH_ROOM);

        configure({$urandom, $urandom, $urandom, $urandom}, '1, 1'b0);
        // New range with the pattern at byte 0 and an all-ones sequence.
        open_range = 1'b1;
        put_pattern();
        put_word('1);
        put_random(BLOCK_BYTES - MATCH_ROOM);
        // Latest position that still leaves room for the sequence; offset wraps.
        put_random(BLOCK_BYTES - MATCH_ROOM);
        put_pattern();
        put_word('0);
        // Pattern repeated at once: only the first match counts.
        put_random(10);
        put_pattern();
        put_pattern();
        put_random(BLOCK_BYTES - 10 - 2 * PATTERN_BYTES);
        // Late first match, one sequence byte short.
        put_random(BLOCK_BYTES - MATCH_ROOM + 1);
        put_pattern();
        put_random(SEQ_BYTES - 1);
        // Pattern straddling two blocks is not found in either.
        put_random(BLOCK_BYTES - 8);
        put_pattern();
        put_random(BLOCK_BYTES - 8);
        // Partial block dropped by a new range, which restarts the block count.
        put_pattern();
        put_word({$urandom, $urandom});
        put_random(1000);
        open_range = 1'b1;
        put_pattern();
        put_word({$urandom, $urandom});
        put_random(BLOCK_BYTES - MATCH_ROOM);
        // Range start on every beat.
        repeat (20) begin
            open_range = 1'b1;
            put_byte(8'($urandom));
        end
    endtask

    initial begin
        logic [2*WORD_W-1:0] pat;
        logic [WORD_W-1:0]   off_word;
        int                  setting;
        int                  goal;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 35;
                    sink_idle_pct = 64;
                end
                1: begin
                    src_idle_pct = 64;
                    sink_idle_pct = 35;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int half = 0; half < 2; half++) begin
                setting = 2 * phase + half;
                pat = {$urandom, $urandom, $urandom, $urandom};
                off_word = {$urandom, $urandom};
                case (setting)
                    0: off_word = '0;
                    1: off_word = '1;
                    2: pat = '1;
                    3: pat = '0;
                    4: begin
                        pat = {PATTERN_BYTES{8'($urandom)}};
                        off_word = WORD_W'(48'hFFFF_FFFF_D000);
                    end
                    default: ;
                endcase
                configure(pat, off_word, setting == 5);
                goal = board.matches_due_total + RESULTS_PER_SETTING;
                while (board.matches_due_total < goal) scan_random_block();
            end
        end

        // A trailing partial block gives nothing.
        near_miss = 1'b0;
        if (room_left() > 1) put_random($urandom_range(1, room_left() - 1));
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.due_matches.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (board.bad_matches == 0 && board.due_matches.size() == 0) begin
            $display("tb_block_pattern_seq_extractor: PASS");
        end else begin
            $display("tb_block_pattern_seq_extractor: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/bpse_pkg.sv
src/bpse_front.sv
src/bpse_fifo.sv
src/bpse_back.sv
src/block_pattern_seq_extractor.sv
dv/tb_block_pattern_seq_extractor.sv
